// ===== rtl/lgme_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation engine, shared definitions
// Widths, register indexes, window and selection types and the birth and survival
// rule used by the next-generation engine with clamped grid edges.
// ----------------------------------------------------------------------------
package lgme_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int IDX_W   = 10;
    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W  = $clog2(MAX_COLUMNS);
    localparam int COUNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam int EMIT_W          = 4;
    localparam int EMIT_UPPER      = 0;
    localparam int EMIT_UPPER_EDGE = 1;
    localparam int EMIT_LOWER      = 2;
    localparam int EMIT_LOWER_EDGE = 3;

    typedef struct packed {
        logic older;
        logic newer;
    } line_word_t;

    // Bit 0 is the oldest column of the window, bit 2 the newest.
    typedef struct packed {
        logic [2:0] top;
        logic [2:0] mid;
        logic [2:0] bot;
    } window_t;

    typedef struct packed {
        logic lower_rows;
        logic edge_col;
        logic row_one;
        logic col_one;
    } win_sel_t;

    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] value,
                                                    input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] size;
        begin
            if (value < DIM_W'(2))
            begin
                size = DIM_W'(2);
            end
            else if (value > limit)
            begin
                size = limit;
            end
            else
            begin
                size = value;
            end
            return IDX_W'(size - DIM_W'(1));
        end
    endfunction

    function automatic logic life_rule(input logic [COUNT_W-1:0] count,
                                       input logic self_alive);
        begin
            if (count == COUNT_W'(3))
            begin
                return 1'b1;
            end
            else if (count == COUNT_W'(2))
            begin
                return self_alive;
            end
            else
            begin
                return 1'b0;
            end
        end
    endfunction

endpackage

// ===== rtl/lgme_line_store.sv =====
// ----------------------------------------------------------------------------
// Life generation engine, line store
// Holds the two completed rows above the arriving row, one word per column,
// with a registered read port and a separate write port.
// ----------------------------------------------------------------------------
module lgme_line_store (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [lgme_pkg::ADDR_W-1:0]  rd_addr,
    output lgme_pkg::line_word_t         rd_data,
    input  logic                         wr_en,
    input  logic [lgme_pkg::ADDR_W-1:0]  wr_addr,
    input  lgme_pkg::line_word_t         wr_data
);

    lgme_pkg::line_word_t line_mem [lgme_pkg::MAX_COLUMNS];
    lgme_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lgme_window_eval.sv =====
// ----------------------------------------------------------------------------
// Life generation engine, window evaluation
// Picks the clamped 3x3 neighbourhood of one cell out of the window and
// applies the birth and survival rule.
// ----------------------------------------------------------------------------
module lgme_window_eval (
    input  lgme_pkg::window_t  window,
    input  lgme_pkg::win_sel_t sel,
    output logic               next_alive,
    output logic               self_alive
);

    logic [2:0] upper;
    logic [2:0] centre;
    logic [2:0] lower;
    logic [2:0] left_bits;
    logic [2:0] mid_bits;
    logic [2:0] right_bits;
    logic [lgme_pkg::COUNT_W-1:0] total;

    always_comb
    begin
        if (sel.lower_rows)
        begin
            upper  = window.mid;
            centre = window.bot;
        end
        else
        begin
            upper  = sel.row_one ? window.mid : window.top;
            centre = window.mid;
        end
        lower = window.bot;

        if (sel.edge_col)
        begin
            left_bits = {upper[1], centre[1], lower[1]};
            mid_bits  = {upper[2], centre[2], lower[2]};
        end
        else
        begin
            left_bits = sel.col_one ? {upper[1], centre[1], lower[1]}
                                    : {upper[0], centre[0], lower[0]};
            mid_bits  = {upper[1], centre[1], lower[1]};
        end
        right_bits = {upper[2], centre[2], lower[2]};

        self_alive = mid_bits[1];
        total = lgme_pkg::COUNT_W'(left_bits[2]) + lgme_pkg::COUNT_W'(left_bits[1])
              + lgme_pkg::COUNT_W'(left_bits[0]) + lgme_pkg::COUNT_W'(mid_bits[2])
              + lgme_pkg::COUNT_W'(mid_bits[0]) + lgme_pkg::COUNT_W'(right_bits[2])
              + lgme_pkg::COUNT_W'(right_bits[1]) + lgme_pkg::COUNT_W'(right_bits[0]);
        next_alive = lgme_pkg::life_rule(total, self_alive);
    end

endmodule

// ===== rtl/life_generation_mirror_edges_unit.sv =====
// ----------------------------------------------------------------------------
// Life generation engine with clamped edges
// Computes the next generation of a Life grid from a raster stream of cells.
//
// The current generation enters on the cell channel, one beat per cell, row 0
// first and column 0 first within a row. Each result beat carries one cell of
// the next generation with its row and column, a changed flag, a mark on the
// final cell and, on that cell only, whether the whole frame stayed stable.
// A cell is computed once the column after it on the row below has arrived,
// so row 0 gives no results, the last cell of a row gives two, and the last
// cell of the frame gives four.
// A cell beat passes the stage-1 register and the window register on its way to
// the result register. The block takes one cell per cycle while no result is
// waiting to be emitted; it holds the cell channel at each row end after row 0,
// at the frame end and on the last row, while the extra results of a cell go out.
// The two earlier rows sit in one column-addressed line store that is read
// and written back once per cell. Reset clears the position to (0, 0), the
// grid to 2 by 2 and sets the stability flag; a register write restarts the frame.
// While the receiver stalls, the result beat holds and the cell channel
// stalls as soon as the pipeline behind it is full.
// ----------------------------------------------------------------------------
module life_generation_mirror_edges_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lgme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgme_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              cell_valid,
    output logic                              cell_stall,
    input  logic                              cell_alive,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [lgme_pkg::IDX_W-1:0]        cell_row,
    output logic [lgme_pkg::IDX_W-1:0]        cell_col,
    output logic                              next_alive,
    output logic                              changed,
    output logic                              last_of_frame,
    output logic                              frame_stable
);

    localparam logic [lgme_pkg::DIM_W-1:0] ROW_LIMIT = lgme_pkg::DIM_W'(lgme_pkg::MAX_ROWS);
    localparam logic [lgme_pkg::DIM_W-1:0] COL_LIMIT = lgme_pkg::DIM_W'(lgme_pkg::MAX_COLUMNS);

    logic [lgme_pkg::IDX_W-1:0] row_last_reg, row_last_next;
    logic [lgme_pkg::IDX_W-1:0] col_last_reg, col_last_next;
    logic [lgme_pkg::IDX_W-1:0] in_row_reg, in_row_next;
    logic [lgme_pkg::IDX_W-1:0] in_col_reg, in_col_next;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_cell_reg;
    logic [lgme_pkg::IDX_W-1:0] s1_row_reg;
    logic [lgme_pkg::IDX_W-1:0] s1_col_reg;

    lgme_pkg::window_t          win_reg, win_next;
    logic [lgme_pkg::EMIT_W-1:0] pend_reg, pend_next, pend_left, emit_mask;
    logic [lgme_pkg::IDX_W-1:0] job_row_reg;
    logic [lgme_pkg::IDX_W-1:0] job_col_reg;
    logic                       job_row_one_reg;
    logic                       job_col_one_reg;

    logic                       res_valid_reg, res_valid_next;
    logic [lgme_pkg::IDX_W-1:0] res_row_reg, res_row_next;
    logic [lgme_pkg::IDX_W-1:0] res_col_reg, res_col_next;
    logic                       res_next_reg, res_next_next;
    logic                       res_chg_reg, res_chg_next;
    logic                       res_last_reg, res_last_next;
    logic                       res_stable_reg, res_stable_next;
    logic                       stable_reg, stable_next;

    logic                       accept;
    logic                       s1_move;
    logic                       out_load;
    logic                       emit_now;
    logic                       s1_last_col;
    logic                       s1_last_row;
    logic                       s1_inner;
    logic [lgme_pkg::EMIT_W-1:0] job_mask;
    lgme_pkg::win_sel_t         sel;
    lgme_pkg::line_word_t       line_rd;
    lgme_pkg::line_word_t       line_wr;
    logic                       eval_next;
    logic                       eval_self;
    logic                       is_final;

    lgme_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (line_rd),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr)
    );

    lgme_window_eval u_window_eval (
        .window     (win_reg),
        .sel        (sel),
        .next_alive (eval_next),
        .self_alive (eval_self)
    );

    always_comb
    begin
        out_load = !res_valid_reg || !result_stall;
        emit_now = out_load && (pend_reg != '0);

        sel.row_one = job_row_one_reg;
        sel.col_one = job_col_one_reg;
        emit_mask   = '0;
        if (pend_reg[lgme_pkg::EMIT_UPPER])
        begin
            emit_mask[lgme_pkg::EMIT_UPPER] = 1'b1;
            sel.lower_rows = 1'b0;
            sel.edge_col   = 1'b0;
        end
        else if (pend_reg[lgme_pkg::EMIT_UPPER_EDGE])
        begin
            emit_mask[lgme_pkg::EMIT_UPPER_EDGE] = 1'b1;
            sel.lower_rows = 1'b0;
            sel.edge_col   = 1'b1;
        end
        else if (pend_reg[lgme_pkg::EMIT_LOWER])
        begin
            emit_mask[lgme_pkg::EMIT_LOWER] = 1'b1;
            sel.lower_rows = 1'b1;
            sel.edge_col   = 1'b0;
        end
        else
        begin
            emit_mask[lgme_pkg::EMIT_LOWER_EDGE] = pend_reg[lgme_pkg::EMIT_LOWER_EDGE];
            sel.lower_rows = 1'b1;
            sel.edge_col   = 1'b1;
        end
        is_final  = emit_mask[lgme_pkg::EMIT_LOWER_EDGE];
        pend_left = emit_now ? (pend_reg & ~emit_mask) : pend_reg;

        s1_move    = s1_valid_reg && (pend_left == '0);
        cell_stall = s1_valid_reg && !s1_move;
        accept     = cell_valid && !cell_stall;

        s1_last_col = (s1_col_reg == col_last_reg);
        s1_last_row = (s1_row_reg == row_last_reg);
        s1_inner    = (s1_col_reg != '0);
        job_mask = '0;
        job_mask[lgme_pkg::EMIT_UPPER]      = s1_inner && (s1_row_reg != '0);
        job_mask[lgme_pkg::EMIT_UPPER_EDGE] = s1_inner && (s1_row_reg != '0) && s1_last_col;
        job_mask[lgme_pkg::EMIT_LOWER]      = s1_inner && s1_last_row;
        job_mask[lgme_pkg::EMIT_LOWER_EDGE] = s1_inner && s1_last_row && s1_last_col;
        pend_next = s1_move ? job_mask : pend_left;

        line_wr.older = line_rd.newer;
        line_wr.newer = s1_cell_reg;
        win_next = win_reg;
        if (s1_move)
        begin
            win_next.top = {line_rd.older, win_reg.top[2:1]};
            win_next.mid = {line_rd.newer, win_reg.mid[2:1]};
            win_next.bot = {s1_cell_reg, win_reg.bot[2:1]};
        end

        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

        row_last_next = row_last_reg;
        col_last_next = col_last_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        if (accept)
        begin
            if (in_col_reg == col_last_reg)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == row_last_reg) ? '0
                              : in_row_reg + lgme_pkg::IDX_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + lgme_pkg::IDX_W'(1);
            end
        end

        res_valid_next  = out_load ? (pend_reg != '0) : res_valid_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_next_next   = res_next_reg;
        res_chg_next    = res_chg_reg;
        res_last_next   = res_last_reg;
        res_stable_next = res_stable_reg;
        stable_next     = stable_reg;
        if (emit_now)
        begin
            res_row_next    = sel.lower_rows ? job_row_reg
                              : job_row_reg - lgme_pkg::IDX_W'(1);
            res_col_next    = sel.edge_col ? job_col_reg
                              : job_col_reg - lgme_pkg::IDX_W'(1);
            res_next_next   = eval_next;
            res_chg_next    = eval_next ^ eval_self;
            res_last_next   = is_final;
            res_stable_next = is_final && stable_reg && !(eval_next ^ eval_self);
            if (is_final)
            begin
                stable_next = 1'b1;
            end
            else if (eval_next ^ eval_self)
            begin
                stable_next = 1'b0;
            end
        end

        if (cfg_write)
        begin
            in_row_next = '0;
            in_col_next = '0;
            stable_next = 1'b1;
            case (cfg_index)
                lgme_pkg::REG_ROW_COUNT:
                begin
                    row_last_next = lgme_pkg::last_index(cfg_data, ROW_LIMIT);
                end
                lgme_pkg::REG_COLUMN_COUNT:
                begin
                    col_last_next = lgme_pkg::last_index(cfg_data, COL_LIMIT);
                end
                default:
                begin
                    row_last_next = row_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_last_reg  <= lgme_pkg::IDX_W'(1);
            col_last_reg  <= lgme_pkg::IDX_W'(1);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
            pend_reg      <= '0;
            res_valid_reg <= 1'b0;
            stable_reg    <= 1'b1;
        end
        else
        begin
            row_last_reg  <= row_last_next;
            col_last_reg  <= col_last_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            stable_reg    <= stable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= cell_alive;
            s1_row_reg  <= in_row_reg;
            s1_col_reg  <= in_col_reg;
        end
        if (s1_move)
        begin
            job_row_reg     <= s1_row_reg;
            job_col_reg     <= s1_col_reg;
            job_row_one_reg <= (s1_row_reg == lgme_pkg::IDX_W'(1));
            job_col_one_reg <= (s1_col_reg == lgme_pkg::IDX_W'(1));
        end
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_next_reg   <= res_next_next;
        res_chg_reg    <= res_chg_next;
        res_last_reg   <= res_last_next;
        res_stable_reg <= res_stable_next;
    end

    assign result_valid  = res_valid_reg;
    assign cell_row      = res_row_reg;
    assign cell_col      = res_col_reg;
    assign next_alive    = res_next_reg;
    assign changed       = res_chg_reg;
    assign last_of_frame = res_last_reg;
    assign frame_stable  = res_stable_reg;

endmodule
